/* hdl/cqs_pkg.sv */
// shared types and constants for the circular queue with search
`timescale 1ns / 1ps

package cqs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned POS_W         = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ,
    MODE_DEQ,
    MODE_SEARCH,
    MODE_DISPLAY
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY,
    STAT_NOT_FOUND
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;
  } result_t;

endpackage

/* hdl/cqs_mem.sv */
// entry storage: one write port, one read port with registered read data
`timescale 1ns / 1ps

module cqs_mem #(
  parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [IW-1:0]                    waddr_i,
  input  logic signed [cqs_pkg::DATA_W-1:0] wdata_i,
  input  logic [IW-1:0]                    raddr_i,
  output logic signed [cqs_pkg::DATA_W-1:0] rdata_o
);
  import cqs_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read in the same cycle as a write to that entry returns the old contents
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/cqs_out.sv */
// output register between the sequencer and the result stream
`timescale 1ns / 1ps

module cqs_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  cqs_pkg::result_t push_res_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cqs_pkg::result_t res_o
);
  import cqs_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign push_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_ready_o) begin
      valid_d = push_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      res_q <= push_res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hdl/cqs_ctrl.sv */
// sequencer: queue pointers, request decode and the search / display walk
`timescale 1ns / 1ps

module cqs_ctrl #(
  parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  cqs_pkg::mode_e                    req_mode_i,
  input  logic signed [cqs_pkg::DATA_W-1:0] req_value_i,
  input  logic signed [cqs_pkg::DATA_W-1:0] req_key_i,
  output logic                              mem_we_o,
  output logic [IW-1:0]                     mem_waddr_o,
  output logic signed [cqs_pkg::DATA_W-1:0] mem_wdata_o,
  output logic [IW-1:0]                     mem_raddr_o,
  input  logic signed [cqs_pkg::DATA_W-1:0] mem_rdata_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output cqs_pkg::result_t                  res_o
);
  import cqs_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

  state_e                   state_q, state_d;
  logic [IW-1:0]            head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic                     empty_q, empty_d;
  logic [CW-1:0]            count_q, count_d, n_q, n_d;
  mode_e                    mode_q, mode_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  result_t                  res_q, res_d;

  logic [IW-1:0] head_next, tail_next, idx_next;
  logic [CW-1:0] count_now, n_inc;
  logic [PW-1:0] pos_ext;
  logic          full, match, walk_end;

  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign idx_next  = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  // number of stored entries
  always_comb begin
    if (empty_q) begin
      count_now = '0;
    end else if (tail_q >= head_q) begin
      count_now = CW'(tail_q - head_q) + 1'b1;
    end else begin
      count_now = CW'(DEPTH) - CW'(head_q) + CW'(tail_q) + 1'b1;
    end
  end

  assign full     = (count_now == CW'(DEPTH));
  assign n_inc    = n_q + 1'b1;
  assign pos_ext  = PW'(n_inc);
  assign match    = (mem_rdata_i == key_q);
  assign walk_end = (n_inc == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_mode_i == MODE_ENQ || empty_q) ? ST_SEND : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (mode_q == MODE_SEARCH && !match && !walk_end) begin
          state_d = ST_EVAL;
        end else begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (res_ready_i) begin
          state_d = res_q.last ? ST_IDLE : ST_EVAL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    idx_d       = idx_q;
    n_d         = n_q;
    count_d     = count_q;
    mode_d      = mode_q;
    key_d       = key_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_next;
    mem_wdata_o = req_value_i;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          mode_d  = req_mode_i;
          key_d   = req_key_i;
          idx_d   = head_q;
          n_d     = '0;
          count_d = count_now;
          res_d   = '{status: STAT_EMPTY, data: '0, position: '0, last: 1'b1};
          if (req_mode_i == MODE_ENQ) begin
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              mem_we_o     = 1'b1;
              res_d.status = STAT_OK;
              empty_d      = 1'b0;
              if (empty_q) begin
                head_d      = '0;
                tail_d      = '0;
                mem_waddr_o = '0;
              end else begin
                tail_d = tail_next;
              end
            end
          end
        end
      end
      ST_EVAL: begin
        res_d = '{status: STAT_OK, data: '0, position: '0, last: 1'b1};
        unique case (mode_q)
          MODE_DEQ: begin
            res_d.data = mem_rdata_i;
            if (head_q == tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else begin
              head_d = head_next;
            end
          end
          MODE_SEARCH: begin
            if (match) begin
              res_d.position = pos_ext[POS_W-1:0];
            end else if (walk_end) begin
              res_d.status = STAT_NOT_FOUND;
            end else begin
              n_d   = n_inc;
              idx_d = idx_next;
            end
          end
          MODE_DISPLAY: begin
            res_d.data = mem_rdata_i;
            res_d.last = walk_end;
          end
          MODE_ENQ: begin
            res_d = res_q;
          end
          default: res_d = res_q;
        endcase
      end
      ST_SEND: begin
        // display: step to the next entry once this one is taken
        if (res_ready_i && !res_q.last) begin
          idx_d = idx_next;
          n_d   = n_inc;
        end
      end
      default: ;
    endcase
  end

  // read address follows the next walk index, so the registered read data lines up with the current index
  assign mem_raddr_o = idx_d;
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_SEND);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    n_q     <= n_d;
    count_q <= count_d;
    mode_q  <= mode_d;
    key_q   <= key_d;
    res_q   <= res_d;
  end

endmodule

/* hdl/circular_queue_with_search_unit.sv */
// top level of the circular queue with search and display
`timescale 1ns / 1ps

// circular FIFO of signed 32-bit values, DEPTH entries in a synchronous memory
// request channel (s_axis): tuser carries the operation (enqueue, dequeue,
//   search, display), tdata the value to store and the key to look for
// result channel (m_axis): tdata carries status, data and position, tlast
//   marks the final result of a request; display gives one result per entry
// one request is worked on at a time; s_axis_tready_o is high only when idle
// sequencing, with a free result channel:
//   enqueue, full or empty cases: idle, then send
//   dequeue: idle, evaluate (one memory read), then send
//   search: idle, evaluate repeated for each entry compared (up to DEPTH entries), then send
//   display: idle, then evaluate and send for each entry in turn, with one memory read per entry
// an output register parts the sequencer from the result channel; when the
//   receiver stalls, results wait there and the sequencer holds its own
// reset empties the queue (pointers to zero); memory contents are not cleared
//   and an entry's contents are never used before it is written
module circular_queue_with_search_unit #(
  parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] value, [63:32] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [1:0] status, [33:2] data, [37:34] position, 0 pad
  output logic        m_axis_tlast_o    // last result of a request
);
  import cqs_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  // memory port between sequencer and storage
  logic                     mem_we;
  logic [IW-1:0]            mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata;

  // sequencer to output register
  logic    push_valid, push_ready;
  result_t push_res, out_res;

  cqs_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_mode_i  (mode_e'(s_axis_tuser_i)),
    .req_value_i (s_axis_tdata_i[31:0]),
    .req_key_i   (s_axis_tdata_i[63:32]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (push_valid),
    .res_ready_i (push_ready),
    .res_o       (push_res)
  );

  cqs_mem #(
    .DEPTH(DEPTH),
    .IW   (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cqs_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_res_i   (push_res),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .res_o        (out_res)
  );

  // pack result fields, status in the lowest bits
  assign m_axis_tdata_o = {2'b0, out_res.position, out_res.data, out_res.status};
  assign m_axis_tlast_o = out_res.last;

endmodule
